// ===== rtl/brb_pkg.sv =====
// Package with shared types, constants and helpers of the byte ring buffer.
package brb_pkg;

  localparam int unsigned DEPTH  = 256;
  localparam int unsigned PTR_W  = $clog2(DEPTH);
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 8;
  localparam int unsigned REQ_W  = 3;

  // Request kinds carried in req_type
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH    = 3'd0,
    REQ_POP     = 3'd1,
    REQ_FILL    = 3'd2,
    REQ_DROP    = 3'd3,
    REQ_CLEAR   = 3'd4,
    REQ_ACQUIRE = 3'd5,
    REQ_CURRENT = 3'd6,
    REQ_RELEASE = 3'd7
  } req_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_POP
  } state_e;

  // Configuration register indexes
  typedef enum logic {
    CFG_INDEX_MASK = 1'b0,
    CFG_UNUSED     = 1'b1
  } cfg_e;

  localparam logic [BYTE_W-1:0] MASK_RESET = 8'hFF;

  // Operands of the shared pointer adder
  typedef struct packed {
    logic [PTR_W-1:0]  base;
    logic [LEN_W-1:0]  addend;
    logic [BYTE_W-1:0] mask;
  } alu_req_t;

  // Bytes held for a pair of pointers under a mask
  function automatic logic [BYTE_W-1:0] held(input logic [PTR_W-1:0] wp,
                                             input logic [PTR_W-1:0] rp,
                                             input logic [BYTE_W-1:0] mask);
    logic [PTR_W-1:0] diff;
    diff = wp - rp;
    return BYTE_W'(diff) & mask;
  endfunction

endpackage

// ===== rtl/brb_if.sv =====
// Request and response channel interfaces of the byte ring buffer.
interface brb_req_if;
  logic                         valid;
  logic                         ready;
  logic [brb_pkg::REQ_W-1:0]    req_type;
  logic [brb_pkg::BYTE_W-1:0]   data_byte;
  logic [brb_pkg::LEN_W-1:0]    length;

  modport source (output valid, req_type, data_byte, length, input ready);
  modport sink   (input valid, req_type, data_byte, length, output ready);
endinterface

interface brb_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         ok;
  logic [brb_pkg::LEN_W-1:0]    done_count;
  logic [brb_pkg::BYTE_W-1:0]   data_out;
  logic [brb_pkg::BYTE_W-1:0]   slot_index;
  logic [brb_pkg::BYTE_W-1:0]   occupancy;

  modport source (output valid, ok, done_count, data_out, slot_index, occupancy,
                  input ready);
  modport sink   (input valid, ok, done_count, data_out, slot_index, occupancy,
                  output ready);
endinterface

// ===== rtl/byte_ring_buffer_unit.sv =====
// Top level of the byte ring buffer: sequencer, byte store, pointers and APB register.
// Usage: a request is taken when the unit is idle and the response register is empty or
// being drained. Push, drop, clear, acquire, current, release and refused requests answer
// in the cycle after transfer; a pop answers via the registered byte store read and then
// the response register; a fill of n bytes (n clamped to free space) writes one byte per
// cycle through the shared pointer adder and loads its answer with its last write. The unit
// takes no new request until the response of the previous one is loaded. The byte store has
// no reset and needs no clearing pass; writing index_mask (address 0) resets both pointers.
module byte_ring_buffer_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  brb_req_if.sink              req_i,
  brb_rsp_if.source            rsp_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int unsigned PW = brb_pkg::PTR_W;
  localparam int unsigned BW = brb_pkg::BYTE_W;
  localparam int unsigned LW = brb_pkg::LEN_W;

  brb_pkg::state_e  state_q, state_d;
  logic [PW-1:0]    wp_q, wp_d, rp_q, rp_d;
  logic [BW-1:0]    mask_q;
  logic [LW-1:0]    remain_q, remain_d;
  logic [BW-1:0]    fill_byte_q, fill_byte_d;
  logic [BW-1:0]    mem [brb_pkg::DEPTH];
  logic [BW-1:0]    rd_data_q;

  logic             out_valid_q;
  logic             out_ok_q;
  logic [LW-1:0]    out_done_q;
  logic [BW-1:0]    out_data_q, out_sidx_q, out_occ_q;

  logic             take, out_free, cfg_wr;
  logic [BW-1:0]    cnt, space;
  logic [LW-1:0]    fill_n, drop_n;

  // Datapath controls from the sequencer
  logic             load, wr_en, rd_en;
  logic [PW-1:0]    wr_addr;
  logic [BW-1:0]    wr_data;
  logic             ld_ok;
  logic [LW-1:0]    ld_done;
  logic [BW-1:0]    ld_data, ld_sidx;

  brb_pkg::alu_req_t alu_req;
  logic [PW-1:0]     alu_sum;

  brb_ptr_alu u_alu (
    .alu_i (alu_req),
    .sum_o (alu_sum)
  );

  // APB register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (brb_pkg::cfg_e'(paddr[2]) == brb_pkg::CFG_INDEX_MASK);
  assign prdata = (brb_pkg::cfg_e'(paddr[2]) == brb_pkg::CFG_INDEX_MASK) ?
                  {{(32 - BW){1'b0}}, mask_q} : 32'd0;

  // Handshake
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == brb_pkg::ST_IDLE) && out_free;
  assign take        = req_i.valid && req_i.ready;

  // Occupancy, free space and clamped run lengths
  assign cnt    = brb_pkg::held(wp_q, rp_q, mask_q);
  assign space  = mask_q - cnt;
  assign fill_n = (req_i.length < LW'(space)) ? req_i.length : LW'(space);
  assign drop_n = (req_i.length < LW'(cnt)) ? req_i.length : LW'(cnt);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      brb_pkg::ST_IDLE: begin
        if (take) begin
          if (brb_pkg::req_e'(req_i.req_type) == brb_pkg::REQ_POP && cnt != '0) begin
            state_d = brb_pkg::ST_POP;
          end else if (brb_pkg::req_e'(req_i.req_type) == brb_pkg::REQ_FILL &&
                       fill_n != '0) begin
            state_d = brb_pkg::ST_FILL;
          end
        end
      end
      brb_pkg::ST_FILL: begin
        if (remain_q == LW'(1)) begin
          state_d = brb_pkg::ST_IDLE;
        end
      end
      brb_pkg::ST_POP: begin
        state_d = brb_pkg::ST_IDLE;
      end
      default: begin
        state_d = brb_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs and pointer updates
  always_comb begin
    load        = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    wr_addr     = wp_q;
    wr_data     = req_i.data_byte;
    ld_ok       = 1'b0;
    ld_done     = '0;
    ld_data     = '0;
    ld_sidx     = '0;
    wp_d        = wp_q;
    rp_d        = rp_q;
    remain_d    = remain_q;
    fill_byte_d = fill_byte_q;
    alu_req     = '{base: wp_q, addend: LW'(1), mask: mask_q};
    unique case (state_q)
      brb_pkg::ST_IDLE: begin
        if (take) begin
          unique case (brb_pkg::req_e'(req_i.req_type))
            brb_pkg::REQ_PUSH: begin
              load = 1'b1;
              if (space != '0) begin
                wr_en   = 1'b1;
                wp_d    = alu_sum;
                ld_ok   = 1'b1;
                ld_done = LW'(1);
              end
            end
            brb_pkg::REQ_POP: begin
              alu_req.base = rp_q;
              if (cnt != '0) begin
                rd_en = 1'b1;
                rp_d  = alu_sum;
              end else begin
                load = 1'b1;
              end
            end
            brb_pkg::REQ_FILL: begin
              if (fill_n != '0) begin
                remain_d    = fill_n;
                fill_byte_d = req_i.data_byte;
              end else begin
                load = 1'b1;
              end
            end
            brb_pkg::REQ_DROP: begin
              alu_req.base   = rp_q;
              alu_req.addend = drop_n;
              rp_d           = alu_sum;
              load           = 1'b1;
              ld_ok          = (drop_n != '0);
              ld_done        = drop_n;
            end
            brb_pkg::REQ_CLEAR: begin
              rp_d  = wp_q;
              load  = 1'b1;
              ld_ok = 1'b1;
            end
            brb_pkg::REQ_ACQUIRE: begin
              load = 1'b1;
              if (cnt < mask_q) begin
                wp_d    = alu_sum;
                ld_ok   = 1'b1;
                ld_sidx = BW'(wp_q);
              end
            end
            brb_pkg::REQ_CURRENT: begin
              load = 1'b1;
              if (cnt != '0) begin
                ld_ok   = 1'b1;
                ld_sidx = BW'(rp_q);
              end
            end
            brb_pkg::REQ_RELEASE: begin
              alu_req.base = rp_q;
              load         = 1'b1;
              if (rp_q != wp_q) begin
                rp_d  = alu_sum;
                ld_ok = 1'b1;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      brb_pkg::ST_FILL: begin
        wr_en    = 1'b1;
        wr_data  = fill_byte_q;
        wp_d     = alu_sum;
        remain_d = remain_q - LW'(1);
        if (remain_q == LW'(1)) begin
          load    = 1'b1;
          ld_ok   = 1'b1;
          ld_done = out_done_q;
        end
      end
      brb_pkg::ST_POP: begin
        load    = 1'b1;
        ld_ok   = 1'b1;
        ld_done = LW'(1);
        ld_data = rd_data_q;
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  // Control registers and pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= brb_pkg::ST_IDLE;
      wp_q        <= '0;
      rp_q        <= '0;
      mask_q      <= brb_pkg::MASK_RESET;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      remain_q <= remain_d;
      if (cfg_wr) begin
        mask_q <= pwdata[BW-1:0];
        wp_q   <= '0;
        rp_q   <= '0;
      end else begin
        wp_q <= wp_d;
        rp_q <= rp_d;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Response payload; hold the fill count in done while the run goes on
  always_ff @(posedge clk_i) begin
    fill_byte_q <= fill_byte_d;
    if (load) begin
      out_ok_q   <= ld_ok;
      out_done_q <= ld_done;
      out_data_q <= ld_data;
      out_sidx_q <= ld_sidx;
      out_occ_q  <= brb_pkg::held(wp_d, rp_d, mask_q);
    end else if (take) begin
      out_done_q <= fill_n;
    end
  end

  // Byte store, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rp_q];
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.ok         = out_ok_q;
  assign rsp_o.done_count = out_done_q;
  assign rsp_o.data_out   = out_data_q;
  assign rsp_o.slot_index = out_sidx_q;
  assign rsp_o.occupancy  = out_occ_q;

`ifndef ASSERT_OFF
  // The response register is never overwritten while a response waits
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && out_valid_q) |-> rsp_o.ready)
    else $error("response overwritten before transfer");

  // Pointers stay within the mask bits
  a_ptr_in_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((wp_q & ~PW'(mask_q)) == '0) && ((rp_q & ~PW'(mask_q)) == '0))
    else $error("pointer outside mask");

  // A fill run never sits with nothing left to write
  a_fill_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == brb_pkg::ST_FILL) |-> (remain_q != '0))
    else $error("fill run with zero count");

  // The last fill write yields a response in the next cycle
  a_fill_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == brb_pkg::ST_FILL && remain_q == LW'(1)) |=>
    (state_q == brb_pkg::ST_IDLE && out_valid_q))
    else $error("fill did not complete");

  // A pop read always finds the response register free
  a_pop_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == brb_pkg::ST_POP) |-> !out_valid_q)
    else $error("pop result with busy response register");
`endif

endmodule

// ===== rtl/brb_ptr_alu.sv =====
// Shared pointer adder: advances a pointer by a count and wraps it under the mask.
module brb_ptr_alu (
  input  brb_pkg::alu_req_t             alu_i,
  output logic [brb_pkg::PTR_W-1:0]     sum_o
);

  logic [brb_pkg::PTR_W-1:0] raw;

  // Add the step, then keep only the mask bits
  assign raw   = alu_i.base + brb_pkg::PTR_W'(alu_i.addend);
  assign sum_o = raw & brb_pkg::PTR_W'(alu_i.mask);

endmodule

// ===== dv/brb_checker.sv =====
// Checker that predicts the ring buffer's responses and compares them with the unit's output.
`timescale 1ns / 100ps
module brb_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  brb_req_if          req_i,
  brb_rsp_if          rsp_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int unsigned error_count_o,
  output int unsigned answered_o
);

  localparam logic [2:0] MASK_ADDR = {brb_pkg::CFG_INDEX_MASK, 2'b00};
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic                       ok;
    logic [brb_pkg::LEN_W-1:0]  done_count;
    logic [brb_pkg::BYTE_W-1:0] data_out;
    logic [brb_pkg::BYTE_W-1:0] slot_index;
    logic [brb_pkg::BYTE_W-1:0] occupancy;
  } ring_rsp_t;

  // Shadow copy of the ring: byte store, head, tail and size mask
  logic [brb_pkg::BYTE_W-1:0] ring_mem [brb_pkg::DEPTH];
  logic [brb_pkg::PTR_W-1:0]  head_ptr;
  logic [brb_pkg::PTR_W-1:0]  tail_ptr;
  logic [brb_pkg::BYTE_W-1:0] size_mask;

  ring_rsp_t   pending_rsp_q[$];
  int unsigned errors;
  int unsigned answered;

  // Apply one request to the shadow ring and return the response it earns
  function automatic ring_rsp_t apply_request(brb_pkg::req_e kind,
                                              logic [brb_pkg::BYTE_W-1:0] value,
                                              logic [brb_pkg::LEN_W-1:0] count);
    ring_rsp_t                  r;
    logic [brb_pkg::BYTE_W-1:0] held_now;
    logic [brb_pkg::BYTE_W-1:0] free_now;
    logic [brb_pkg::BYTE_W-1:0] n;
    r        = '0;
    held_now = brb_pkg::BYTE_W'(head_ptr - tail_ptr) & size_mask;
    free_now = size_mask - held_now;
    case (kind)
      brb_pkg::REQ_PUSH: begin
        if (free_now != 0) begin
          ring_mem[head_ptr] = value;
          head_ptr     = brb_pkg::PTR_W'(head_ptr + 1) & size_mask;
          r.ok         = 1'b1;
          r.done_count = brb_pkg::LEN_W'(1);
        end
      end
      brb_pkg::REQ_POP: begin
        if (held_now != 0) begin
          r.data_out   = ring_mem[tail_ptr];
          tail_ptr     = brb_pkg::PTR_W'(tail_ptr + 1) & size_mask;
          r.ok         = 1'b1;
          r.done_count = brb_pkg::LEN_W'(1);
        end
      end
      brb_pkg::REQ_FILL: begin
        n = (count < free_now) ? count : free_now;
        for (int i = 0; i < int'(n); i++) begin
          ring_mem[head_ptr] = value;
          head_ptr = brb_pkg::PTR_W'(head_ptr + 1) & size_mask;
        end
        r.done_count = n;
        r.ok         = (n != 0);
      end
      brb_pkg::REQ_DROP: begin
        n = (count < held_now) ? count : held_now;
        tail_ptr     = brb_pkg::PTR_W'(tail_ptr + n) & size_mask;
        r.done_count = n;
        r.ok         = (n != 0);
      end
      brb_pkg::REQ_CLEAR: begin
        tail_ptr = head_ptr;
        r.ok     = 1'b1;
      end
      brb_pkg::REQ_ACQUIRE: begin
        if (held_now < size_mask) begin
          r.slot_index = head_ptr;
          head_ptr     = brb_pkg::PTR_W'(head_ptr + 1) & size_mask;
          r.ok         = 1'b1;
        end
      end
      brb_pkg::REQ_CURRENT: begin
        if (held_now != 0) begin
          r.slot_index = tail_ptr;
          r.ok         = 1'b1;
        end
      end
      default: begin
        // release tests the raw pointers, not the occupancy
        if (tail_ptr != head_ptr) begin
          tail_ptr = brb_pkg::PTR_W'(tail_ptr + 1) & size_mask;
          r.ok     = 1'b1;
        end
      end
    endcase
    r.occupancy = brb_pkg::BYTE_W'(head_ptr - tail_ptr) & size_mask;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ring_rsp_t seen;
    ring_rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < int'(brb_pkg::DEPTH); i++) ring_mem[i] = '0;
      head_ptr  = '0;
      tail_ptr  = '0;
      size_mask = brb_pkg::MASK_RESET;
      pending_rsp_q.delete();
      errors    = 0;
      answered  = 0;
    end else begin
      // Compare a response transfer with the oldest prediction
      if (rsp_i.valid && rsp_i.ready) begin
        seen.ok         = rsp_i.ok;
        seen.done_count = rsp_i.done_count;
        seen.data_out   = rsp_i.data_out;
        seen.slot_index = rsp_i.slot_index;
        seen.occupancy  = rsp_i.occupancy;
        answered++;
        if (pending_rsp_q.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("ERROR %0t: response with none expected:", $time,
                     " ok=%0b done=%0d data=%02h slot=%0d occ=%0d",
                     seen.ok, seen.done_count, seen.data_out, seen.slot_index,
                     seen.occupancy);
        end else begin
          want = pending_rsp_q.pop_front();
          if (seen.ok !== want.ok || seen.done_count !== want.done_count ||
              seen.data_out !== want.data_out || seen.slot_index !== want.slot_index ||
              seen.occupancy !== want.occupancy) begin
            errors++;
            if (errors <= REPORT_LIMIT)
              $display("ERROR %0t:", $time,
                       " expected ok=%0b done=%0d data=%02h slot=%0d occ=%0d,",
                       want.ok, want.done_count, want.data_out, want.slot_index,
                       want.occupancy,
                       " got ok=%0b done=%0d data=%02h slot=%0d occ=%0d",
                       seen.ok, seen.done_count, seen.data_out, seen.slot_index,
                       seen.occupancy);
          end
        end
      end
      // Mask write resets both pointers; other addresses are ignored
      if (psel && penable && pwrite && pready && paddr == MASK_ADDR) begin
        size_mask = pwdata[brb_pkg::BYTE_W-1:0];
        head_ptr  = '0;
        tail_ptr  = '0;
      end
      // Predict the response of a request transfer
      if (req_i.valid && req_i.ready)
        pending_rsp_q.push_back(apply_request(brb_pkg::req_e'(req_i.req_type),
                                              req_i.data_byte, req_i.length));
    end
    error_count_o <= errors;
    answered_o    <= answered;
  end

endmodule

// ===== dv/testbench.sv =====
// Top of the byte ring buffer testbench: clock, reset, request traffic and verdict.
`timescale 1ns / 100ps
module testbench;

  localparam logic [2:0] MASK_ADDR   = {brb_pkg::CFG_INDEX_MASK, 2'b00};
  localparam logic [2:0] UNUSED_ADDR = {brb_pkg::CFG_UNUSED, 2'b00};
  localparam int unsigned PHASE_ITEMS = 115;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned error_count;
  int unsigned answered;
  int unsigned sent;
  int unsigned rsp_hold;
  bit          rsp_calm;
  bit          req_calm;

  brb_req_if req_ch ();
  brb_rsp_if rsp_ch ();

  byte_ring_buffer_unit u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_ch),
    .rsp_o   (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  brb_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_ch),
    .rsp_i         (rsp_ch),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .error_count_o (error_count),
    .answered_o    (answered)
  );

  // Clock
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Response side: stall at random, with calm stretches
  always @(posedge clk_i) begin
    if (rsp_hold != 0) begin
      rsp_ch.ready <= 1'b0;
      rsp_hold     <= rsp_hold - 1;
    end else begin
      rsp_ch.ready <= 1'b1;
      if ($urandom_range(0, 199) == 0) rsp_calm <= !rsp_calm;
      if (!rsp_calm && $urandom_range(0, 99) < 20) rsp_hold <= pick_gap();
    end
  end

  // Issue one request; valid stays high when the next one follows back to back
  task automatic send_req(brb_pkg::req_e kind, logic [brb_pkg::BYTE_W-1:0] value,
                          logic [brb_pkg::LEN_W-1:0] count);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(0, 149) == 0) req_calm = !req_calm;
    if (!req_calm && $urandom_range(0, 99) < 25) gap = pick_gap();
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= kind;
    req_ch.data_byte <= value;
    req_ch.length    <= count;
    do @(posedge clk_i); while (!req_ch.ready);
    sent++;
  endtask

  // Hold off until every response has come back
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (answered < sent) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Random traffic under one mask setting
  task automatic random_phase(int unsigned items, logic [brb_pkg::BYTE_W-1:0] mask);
    brb_pkg::req_e             kind;
    int unsigned               roll;
    logic [brb_pkg::LEN_W-1:0] count;
    for (int unsigned k = 0; k < items; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 25)      kind = brb_pkg::REQ_PUSH;
      else if (roll < 50) kind = brb_pkg::REQ_POP;
      else if (roll < 60) kind = brb_pkg::REQ_FILL;
      else if (roll < 68) kind = brb_pkg::REQ_DROP;
      else if (roll < 72) kind = brb_pkg::REQ_CLEAR;
      else if (roll < 82) kind = brb_pkg::REQ_ACQUIRE;
      else if (roll < 90) kind = brb_pkg::REQ_CURRENT;
      else                kind = brb_pkg::REQ_RELEASE;
      roll = $urandom_range(0, 9);
      if (roll < 6)      count = brb_pkg::LEN_W'($urandom_range(0, 7));
      else if (roll < 9) count = brb_pkg::LEN_W'($urandom_range(0, 32'(mask)));
      else               count = brb_pkg::LEN_W'($urandom_range(0, 255));
      send_req(kind, brb_pkg::BYTE_W'($urandom_range(0, 255)), count);
      if ($urandom_range(0, 63) == 0) wait_drained();
    end
  endtask

  // Stimulus and verdict
  initial begin
    logic [brb_pkg::BYTE_W-1:0] masks [9];
    masks = '{8'hFF, 8'h01, 8'h03, 8'h00, 8'hFF, 8'h5A, 8'h0F, 8'h80, 8'h3F};
    rst_ni           = 1'b0;
    req_ch.valid     = 1'b0;
    req_ch.req_type  = brb_pkg::REQ_PUSH;
    req_ch.data_byte = '0;
    req_ch.length    = '0;
    rsp_ch.ready     = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    rsp_hold         = 0;
    rsp_calm         = 1'b0;
    req_calm         = 1'b0;
    sent             = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Refusals on an empty ring
    send_req(brb_pkg::REQ_POP, 8'h00, 8'd0);
    send_req(brb_pkg::REQ_CURRENT, 8'h00, 8'd0);
    send_req(brb_pkg::REQ_RELEASE, 8'h00, 8'd0);
    send_req(brb_pkg::REQ_DROP, 8'h00, 8'd255);
    send_req(brb_pkg::REQ_FILL, 8'h00, 8'd0);
    // Fill to capacity, which also writes every slot but the last
    send_req(brb_pkg::REQ_FILL, 8'hA5, 8'd255);
    send_req(brb_pkg::REQ_PUSH, 8'hFF, 8'd0);
    send_req(brb_pkg::REQ_ACQUIRE, 8'h00, 8'd0);
    send_req(brb_pkg::REQ_FILL, 8'h5A, 8'd1);
    send_req(brb_pkg::REQ_CURRENT, 8'h00, 8'd0);
    send_req(brb_pkg::REQ_DROP, 8'h00, 8'd255);
    // Wrap through the last slot so the whole store has been written
    send_req(brb_pkg::REQ_PUSH, 8'h00, 8'd0);
    send_req(brb_pkg::REQ_PUSH, 8'hFF, 8'd0);
    send_req(brb_pkg::REQ_POP, 8'h00, 8'd0);
    send_req(brb_pkg::REQ_POP, 8'h00, 8'd0);
    send_req(brb_pkg::REQ_ACQUIRE, 8'h00, 8'd0);
    send_req(brb_pkg::REQ_ACQUIRE, 8'h00, 8'd0);
    send_req(brb_pkg::REQ_CURRENT, 8'h00, 8'd0);
    send_req(brb_pkg::REQ_RELEASE, 8'h00, 8'd0);
    send_req(brb_pkg::REQ_RELEASE, 8'h00, 8'd0);
    send_req(brb_pkg::REQ_RELEASE, 8'h00, 8'd0);
    send_req(brb_pkg::REQ_PUSH, 8'h5A, 8'd0);
    send_req(brb_pkg::REQ_CLEAR, 8'h00, 8'd0);
    send_req(brb_pkg::REQ_DROP, 8'h00, 8'd0);

    // Write to an unmapped register, then run on the reset mask
    wait_drained();
    apb_write(UNUSED_ADDR, $urandom());
    random_phase(PHASE_ITEMS, brb_pkg::MASK_RESET);

    // Sweep the mask, including zero, the extremes and odd shapes
    for (int p = 1; p < 9; p++) begin
      wait_drained();
      apb_write(MASK_ADDR, ($urandom() & 32'hFFFF_FF00) | 32'(masks[p]));
      random_phase(PHASE_ITEMS, masks[p]);
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
